// File: design/idea_pkg.sv
// Shared types, constants and the encryption subkey function of the IDEA CBC block.
package idea_pkg;

    localparam int ROUND_COUNT = 8;
    localparam int NKEYS       = 52;
    localparam int LAST_KEY    = 6 * ROUND_COUNT;
    localparam int RND_W       = $clog2(ROUND_COUNT + 1);
    localparam int INV_COUNT   = 2 * (ROUND_COUNT + 1);
    localparam int INV_AW      = $clog2(INV_COUNT);
    localparam int KEY_IDX_W   = 6;
    localparam int SQ_STEPS    = 16;
    localparam int SQ_W        = 4;

    localparam logic [63:0] PAD_BLOCK = 64'h0808080808080808;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VECTOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT     = 2'd3;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_BUILD,
        T_KICK,
        T_RUN,
        T_DONE
    } top_state_t;

    typedef enum logic [2:0] {
        KG_IDLE,
        KG_LOAD,
        KG_MUL_R,
        KG_MUL_B,
        KG_SQUARE
    } kg_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_S0,
        C_S1,
        C_S2,
        C_S3,
        C_S4
    } core_state_t;

    // Encryption subkey n: the key rotated left by 25 bits per group of eight words.
    function automatic logic [15:0] e_word(input logic [127:0] key,
                                           input logic [KEY_IDX_W-1:0] n);
        logic [127:0] rot;
        logic [2:0]   w;
        w = n[2:0];
        case (n[5:3])
            3'd0: rot = key;
            3'd1: rot = {key[102:0], key[127:103]};
            3'd2: rot = {key[77:0],  key[127:78]};
            3'd3: rot = {key[52:0],  key[127:53]};
            3'd4: rot = {key[27:0],  key[127:28]};
            3'd5: rot = {key[2:0],   key[127:3]};
            3'd6: rot = {key[105:0], key[127:106]};
            default: rot = key;
        endcase
        return rot[16 * (7 - int'(w)) +: 16];
    endfunction

endpackage

// File: design/idea_mul.sv
// Registered multiplier modulo 65537, a zero word standing for 65536.
module idea_mul (
    input  logic                aclk,
    input  idea_pkg::mul_req_t  req,
    output logic [15:0]         p
);

    logic [31:0] prod;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] p_next;
    logic [15:0] p_reg;

    assign prod = 32'(req.a) * 32'(req.b);
    assign lo   = prod[15:0];
    assign hi   = prod[31:16];

    always_comb begin
        if (req.a == 16'h0) begin
            p_next = 16'h1 - req.b;
        end else if (req.b == 16'h0) begin
            p_next = 16'h1 - req.a;
        end else begin
            p_next = lo - hi + {15'h0, (lo < hi)};
        end
    end

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// File: design/idea_keygen.sv
// Sequencer that builds the inverse subkeys by square-and-multiply and holds them.
module idea_keygen (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [127:0]                     key,
    input  logic [15:0]                      mul_p,
    output idea_pkg::mul_req_t               mul_req,
    input  logic [idea_pkg::INV_AW-1:0]      rd_addr,
    output logic [15:0]                      rd_data,
    output idea_pkg::unit_status_t           status
);

    idea_pkg::kg_state_t state_reg, state_next;
    logic [idea_pkg::INV_AW-1:0] ent_reg;
    logic [idea_pkg::SQ_W-1:0]   sq_reg;
    logic [15:0]                 r_reg;
    logic [15:0]                 base_reg;
    logic                        done_reg;
    logic [15:0]                 inv_tab [idea_pkg::INV_COUNT];
    logic [idea_pkg::KEY_IDX_W-1:0] src_idx;
    logic                        last_sq;
    logic                        last_ent;

    // Inverse entry 2g comes from subkey LAST-6g, entry 2g+1 from LAST+3-6g.
    always_comb begin
        int g;
        g = int'(ent_reg >> 1);
        if (ent_reg[0]) begin
            src_idx = idea_pkg::KEY_IDX_W'(idea_pkg::LAST_KEY + 3 - 6 * g);
        end else begin
            src_idx = idea_pkg::KEY_IDX_W'(idea_pkg::LAST_KEY - 6 * g);
        end
    end

    assign last_sq  = (sq_reg == idea_pkg::SQ_W'(idea_pkg::SQ_STEPS - 1));
    assign last_ent = (ent_reg == idea_pkg::INV_AW'(idea_pkg::INV_COUNT - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            idea_pkg::KG_IDLE: begin
                if (start) begin
                    state_next = idea_pkg::KG_LOAD;
                end
            end
            idea_pkg::KG_LOAD:   state_next = idea_pkg::KG_MUL_R;
            idea_pkg::KG_MUL_R:  state_next = idea_pkg::KG_MUL_B;
            idea_pkg::KG_MUL_B: begin
                if (!last_sq) begin
                    state_next = idea_pkg::KG_SQUARE;
                end else if (last_ent) begin
                    state_next = idea_pkg::KG_IDLE;
                end else begin
                    state_next = idea_pkg::KG_LOAD;
                end
            end
            idea_pkg::KG_SQUARE: state_next = idea_pkg::KG_MUL_R;
            default:             state_next = idea_pkg::KG_IDLE;
        endcase
    end

    always_comb begin
        mul_req.a = base_reg;
        mul_req.b = base_reg;
        case (state_reg)
            idea_pkg::KG_MUL_R: begin
                mul_req.a = r_reg;
                mul_req.b = base_reg;
            end
            default: begin
                mul_req.a = base_reg;
                mul_req.b = base_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= idea_pkg::KG_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == idea_pkg::KG_MUL_B) && last_sq && last_ent;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            idea_pkg::KG_IDLE: begin
                if (start) begin
                    ent_reg <= '0;
                end
            end
            idea_pkg::KG_LOAD: begin
                base_reg <= idea_pkg::e_word(key, src_idx);
                r_reg    <= 16'h1;
                sq_reg   <= '0;
            end
            idea_pkg::KG_MUL_B: begin
                if (last_sq) begin
                    inv_tab[ent_reg] <= mul_p;
                    ent_reg          <= ent_reg + idea_pkg::INV_AW'(1);
                end else begin
                    r_reg <= mul_p;
                end
            end
            idea_pkg::KG_SQUARE: begin
                base_reg <= mul_p;
                sq_reg   <= sq_reg + idea_pkg::SQ_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign rd_data     = inv_tab[rd_addr];
    assign status.busy = (state_reg != idea_pkg::KG_IDLE);
    assign status.done = done_reg;

endmodule

// File: design/idea_core.sv
// Round sequencer of one IDEA block on the shared modular multiplier.
module idea_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic                             decrypt,
    input  logic [127:0]                     key,
    input  logic [63:0]                      blk,
    input  logic [15:0]                      mul_p,
    output idea_pkg::mul_req_t               mul_req,
    output logic [idea_pkg::INV_AW-1:0]      inv_addr,
    input  logic [15:0]                      inv_data,
    output logic [63:0]                      y,
    output idea_pkg::unit_status_t           status
);

    idea_pkg::core_state_t state_reg, state_next;
    logic [idea_pkg::RND_W-1:0] round_reg;
    logic [15:0] x1_reg, x2_reg, x3_reg, x4_reg;
    logic [15:0] s1_reg, s2_reg, s3_reg, s4_reg, s7_reg;
    logic [63:0] y_reg;
    logic        done_reg;
    logic        final_rnd;
    logic [15:0] k1, k2, kmul;
    logic [15:0] s10;

    assign final_rnd = (round_reg == idea_pkg::RND_W'(idea_pkg::ROUND_COUNT));

    // Subkeys of the current round; decryption uses negated, swapped or inverted ones.
    always_comb begin
        int  r;
        int  d;
        int  mi;
        logic outer;
        logic [idea_pkg::KEY_IDX_W-1:0] i1, i2, im;
        r     = int'(round_reg);
        d     = 6 * (idea_pkg::ROUND_COUNT - r);
        outer = (round_reg == '0) || final_rnd;
        mi    = 6 * r;
        case (state_reg)
            idea_pkg::C_S1: mi = 6 * r + 3;
            idea_pkg::C_S2: mi = decrypt ? d - 2 : 6 * r + 4;
            idea_pkg::C_S3: mi = decrypt ? d - 1 : 6 * r + 5;
            default:        mi = 6 * r;
        endcase
        im = idea_pkg::KEY_IDX_W'(mi);
        if (decrypt) begin
            i1 = idea_pkg::KEY_IDX_W'(outer ? d + 1 : d + 2);
            i2 = idea_pkg::KEY_IDX_W'(outer ? d + 2 : d + 1);
            k1 = 16'h0 - idea_pkg::e_word(key, i1);
            k2 = 16'h0 - idea_pkg::e_word(key, i2);
        end else begin
            i1 = idea_pkg::KEY_IDX_W'(6 * r + 1);
            i2 = idea_pkg::KEY_IDX_W'(6 * r + 2);
            k1 = idea_pkg::e_word(key, i1);
            k2 = idea_pkg::e_word(key, i2);
        end
        inv_addr = idea_pkg::INV_AW'(2 * r + ((state_reg == idea_pkg::C_S1) ? 1 : 0));
        if (decrypt && (state_reg == idea_pkg::C_S0 || state_reg == idea_pkg::C_S1)) begin
            kmul = inv_data;
        end else begin
            kmul = idea_pkg::e_word(key, im);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            idea_pkg::C_IDLE: begin
                if (start) begin
                    state_next = idea_pkg::C_S0;
                end
            end
            idea_pkg::C_S0: state_next = idea_pkg::C_S1;
            idea_pkg::C_S1: state_next = idea_pkg::C_S2;
            idea_pkg::C_S2: state_next = final_rnd ? idea_pkg::C_IDLE : idea_pkg::C_S3;
            idea_pkg::C_S3: state_next = idea_pkg::C_S4;
            idea_pkg::C_S4: state_next = idea_pkg::C_S0;
            default:        state_next = idea_pkg::C_IDLE;
        endcase
    end

    always_comb begin
        case (state_reg)
            idea_pkg::C_S0: begin
                mul_req.a = x1_reg;
                mul_req.b = kmul;
            end
            idea_pkg::C_S1: begin
                mul_req.a = x4_reg;
                mul_req.b = kmul;
            end
            idea_pkg::C_S2: begin
                mul_req.a = kmul;
                mul_req.b = s1_reg ^ s3_reg;
            end
            idea_pkg::C_S3: begin
                mul_req.a = kmul;
                mul_req.b = (s2_reg ^ s4_reg) + mul_p;
            end
            default: begin
                mul_req.a = x1_reg;
                mul_req.b = kmul;
            end
        endcase
    end

    assign s10 = s7_reg + mul_p;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= idea_pkg::C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == idea_pkg::C_S2) && final_rnd;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            idea_pkg::C_IDLE: begin
                if (start) begin
                    x1_reg    <= blk[63:48];
                    x2_reg    <= blk[47:32];
                    x3_reg    <= blk[31:16];
                    x4_reg    <= blk[15:0];
                    round_reg <= '0;
                end
            end
            idea_pkg::C_S0: begin
                s2_reg <= x2_reg + k1;
                s3_reg <= x3_reg + k2;
            end
            idea_pkg::C_S1: s1_reg <= mul_p;
            idea_pkg::C_S2: begin
                s4_reg <= mul_p;
                if (final_rnd) begin
                    y_reg <= {s1_reg, x3_reg + k1, x2_reg + k2, mul_p};
                end
            end
            idea_pkg::C_S3: s7_reg <= mul_p;
            idea_pkg::C_S4: begin
                x1_reg    <= s1_reg ^ mul_p;
                x2_reg    <= s3_reg ^ mul_p;
                x3_reg    <= s2_reg ^ s10;
                x4_reg    <= s4_reg ^ s10;
                round_reg <= round_reg + idea_pkg::RND_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign y           = y_reg;
    assign status.busy = (state_reg != idea_pkg::C_IDLE);
    assign status.done = done_reg;

endmodule

// File: design/idea_cbc_block_cipher.sv
// Top level of the IDEA CBC block cipher with padding and pad report.
// Each accepted request runs 8 rounds and the output transform on the one shared
// mod-65537 multiplier. A new request is taken only once the previous block, and any
// pad block that it owes, has gone to the output register; a full last encrypt group
// adds a pad block after it, and a request after a key write first builds the 18
// inverse subkeys. Reset (aresetn low, synchronous) clears the configuration and
// control registers, the chain value and the subkeys-ready flag.
module idea_cbc_block_cipher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // data_in[63:0], byte_count[67:64], zero fill
    input  logic        s_tuser,   // first_group
    input  logic        s_tlast,   // last_group
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // data_out[63:0], valid_bytes[67:64], zero fill
    output logic        m_tuser,   // pad_error
    output logic        m_tlast,   // last_out
    input  logic        cfg_wr_en,
    input  logic [idea_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [63:0] cfg_wr_data
);

    // Configuration registers.
    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [63:0] iv_reg;
    logic        decrypt_reg;
    logic        ready_reg;   // subkeys built for the current key

    // Request context and chain.
    idea_pkg::top_state_t state_reg, state_next;
    logic [63:0] chain_reg;
    logic [63:0] prev_reg;
    logic [63:0] data_reg;
    logic [63:0] blk_reg;
    logic        last_reg;
    logic        need2_reg;   // a full last encrypt group still owes the pad block
    logic        second_reg;  // the block at work is that pad block

    // Output register.
    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic [3:0]  m_count_reg;
    logic        m_last_reg;
    logic        m_err_reg;

    logic        s_acc;
    logic        out_free;
    logic [127:0] key;
    logic [63:0] prev_in;
    logic [63:0] blk_in;
    logic [3:0]  bc_sat;
    logic        need2_in;

    idea_pkg::mul_req_t     kg_req, core_req, mul_req;
    idea_pkg::unit_status_t kg_stat, core_stat;
    logic [15:0]            mul_p;
    logic [idea_pkg::INV_AW-1:0] inv_addr;
    logic [15:0]            inv_data;
    logic [63:0]            core_y;
    logic                   kg_start;
    logic                   core_start;

    logic [63:0] res_data;
    logic [3:0]  res_count;
    logic        res_last;
    logic        res_err;

    assign key      = {key_high_reg, key_low_reg};
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Input block: in encrypt mode a short last group is padded with the pad count,
    // then chained with the previous ciphertext or the IV.
    always_comb begin
        logic [63:0] padded;
        logic [3:0]  bc;
        logic [7:0]  pad;
        bc      = s_tdata[67:64];
        bc_sat  = (bc > 4'd8) ? 4'd8 : bc;
        pad     = 8'(4'd8 - bc_sat);
        prev_in = s_tuser ? iv_reg : chain_reg;
        for (int j = 0; j < 8; j++) begin
            if (4'(j) < bc_sat) begin
                padded[63 - 8 * j -: 8] = s_tdata[63 - 8 * j -: 8];
            end else begin
                padded[63 - 8 * j -: 8] = pad;
            end
        end
        if (decrypt_reg) begin
            blk_in = s_tdata[63:0];
        end else if (s_tlast) begin
            blk_in = padded ^ prev_in;
        end else begin
            blk_in = s_tdata[63:0] ^ prev_in;
        end
        need2_in = !decrypt_reg && s_tlast && (bc_sat == 4'd8);
    end

    // Result of the finished block. In decrypt mode the last plaintext byte is the pad.
    always_comb begin
        logic [63:0] plain;
        logic [7:0]  pb;
        plain     = core_y ^ prev_reg;
        pb        = plain[7:0];
        res_count = 4'd8;
        res_err   = 1'b0;
        if (decrypt_reg) begin
            res_data = plain;
            res_last = last_reg;
            if (last_reg) begin
                res_err = (pb == 8'd0) || (pb > 8'd8);
                if (pb > 8'd8) begin
                    res_count = 4'd0;
                end else if (pb != 8'd0) begin
                    res_count = 4'(8'd8 - pb);
                end
            end
        end else begin
            res_data = core_y;
            res_last = second_reg || (last_reg && !need2_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            idea_pkg::T_IDLE: begin
                if (s_acc) begin
                    state_next = ready_reg ? idea_pkg::T_KICK : idea_pkg::T_BUILD;
                end
            end
            idea_pkg::T_BUILD: begin
                if (kg_stat.done) begin
                    state_next = idea_pkg::T_KICK;
                end
            end
            idea_pkg::T_KICK: state_next = idea_pkg::T_RUN;
            idea_pkg::T_RUN: begin
                if (core_stat.done) begin
                    state_next = idea_pkg::T_DONE;
                end
            end
            idea_pkg::T_DONE: begin
                if (out_free) begin
                    state_next = need2_reg ? idea_pkg::T_KICK : idea_pkg::T_IDLE;
                end
            end
            default: state_next = idea_pkg::T_IDLE;
        endcase
    end

    // The multiplier belongs to the subkey builder while building, else to the rounds.
    always_comb begin
        s_tready   = (state_reg == idea_pkg::T_IDLE);
        kg_start   = (state_reg == idea_pkg::T_IDLE) && s_acc && !ready_reg;
        core_start = (state_reg == idea_pkg::T_KICK);
        case (state_reg)
            idea_pkg::T_BUILD: mul_req = kg_req;
            default:           mul_req = core_req;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= idea_pkg::T_IDLE;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_reg       <= '0;
            decrypt_reg  <= 1'b0;
            ready_reg    <= 1'b0;
            chain_reg    <= '0;
            m_valid_reg  <= 1'b0;
            need2_reg    <= 1'b0;
            second_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    idea_pkg::CFG_KEY_HIGH: begin
                        key_high_reg <= cfg_wr_data;
                        ready_reg    <= 1'b0;
                    end
                    idea_pkg::CFG_KEY_LOW: begin
                        key_low_reg <= cfg_wr_data;
                        ready_reg   <= 1'b0;
                    end
                    idea_pkg::CFG_INIT_VECTOR: iv_reg <= cfg_wr_data;
                    idea_pkg::CFG_DECRYPT:     decrypt_reg <= cfg_wr_data[0];
                    default: begin
                    end
                endcase
            end else if (kg_stat.done) begin
                ready_reg <= 1'b1;
            end
            if (s_acc) begin
                need2_reg  <= need2_in;
                second_reg <= 1'b0;
            end
            if (state_reg == idea_pkg::T_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                chain_reg   <= decrypt_reg ? data_reg : core_y;
                if (need2_reg) begin
                    need2_reg  <= 1'b0;
                    second_reg <= 1'b1;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    function automatic logic [63:0] PAD_XOR(input logic [63:0] c);
        return c ^ idea_pkg::PAD_BLOCK;
    endfunction

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            prev_reg <= prev_in;
            data_reg <= s_tdata[63:0];
            blk_reg  <= blk_in;
            last_reg <= s_tlast;
        end
        if (state_reg == idea_pkg::T_DONE && out_free) begin
            m_data_reg  <= res_data;
            m_count_reg <= res_count;
            m_last_reg  <= res_last;
            m_err_reg   <= res_err;
            blk_reg     <= PAD_XOR(core_y);
        end
    end

    idea_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .p    (mul_p)
    );

    idea_keygen u_keygen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (kg_start),
        .key     (key),
        .mul_p   (mul_p),
        .mul_req (kg_req),
        .rd_addr (inv_addr),
        .rd_data (inv_data),
        .status  (kg_stat)
    );

    idea_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (core_start),
        .decrypt  (decrypt_reg),
        .key      (key),
        .blk      (blk_reg),
        .mul_p    (mul_p),
        .mul_req  (core_req),
        .inv_addr (inv_addr),
        .inv_data (inv_data),
        .y        (core_y),
        .status   (core_stat)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'h0, m_count_reg, m_data_reg};
    assign m_tuser  = m_err_reg;
    assign m_tlast  = m_last_reg;

    // The subkey builder and the rounds never hold the multiplier at the same time.
    a_mul_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(kg_stat.busy && core_stat.busy))
        else $error("subkey builder and round sequencer both active");

    // A request without built subkeys goes through the build first.
    a_build_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !ready_reg) |=> (state_reg == idea_pkg::T_BUILD))
        else $error("request started without subkeys");

    // The rounds finish only while the top level waits for them.
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        core_stat.done |-> (state_reg == idea_pkg::T_RUN))
        else $error("block finished outside the run state");

    // A pad error is only reported on the last block of a message.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("pad error on a block that is not last");

endmodule
